[rtl/rtp_pcmu_packetizer_top_defines.svh]
// Assertion macros for the RTP mu-law packetizer.
`ifndef RTP_PCMU_PACKETIZER_TOP_DEFINES_SVH
`define RTP_PCMU_PACKETIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RPP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define RPP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/rtppcmu_pkg.sv]
// Shared constants for the RTP mu-law packetizer.
package rtppcmu_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ID = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SEQUENCE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_TIMESTAMP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_KIND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 3'd4;

	localparam logic [7:0] FRAME_LENGTH_RESET = 8'd160;

	localparam int unsigned BYTE_IDX_W = 4;
	localparam logic [BYTE_IDX_W-1:0] BYTE_IDX_FIRST = 4'd0;
	localparam logic [BYTE_IDX_W-1:0] BYTE_IDX_PAYLOAD = 4'd12;
	localparam int unsigned PACKET_SLOTS = 13;

	localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
	localparam logic [16:0] MULAW_CLIP = 17'd32635;
	localparam logic [14:0] MULAW_BIAS = 15'h0084;

endpackage

[rtl/rtp_pcmu_packetizer_top.sv]
// RTP packetizer top level: mu-law encoding, header insertion and byte stream output.
// The first output byte of an accepted word goes through the sequencing stage, then the output register.
// One output byte per cycle while m_tready does not hold the output; a frame's first sample gives
// 13 bytes (12 header bytes plus payload), every other sample gives 1 byte.
// The single byte-sequencing stage between input and output register sets this rate.
// Reset (arst_n low, asynchronous): counters and frame position cleared, frame length 160.
`include "rtp_pcmu_packetizer_top_defines.svh"

module rtp_pcmu_packetizer_top #(
	parameter int unsigned MAX_FRAME_SAMPLES = 255
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [15:0]                          s_tdata,   // [15:0] pcm_sample
	input  logic                                 s_tuser,   // [0] marker_bit
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [7:0]                           m_tdata,   // [7:0] packet_byte
	output logic                                 m_tlast,   // end_of_packet
	input  logic                                 cfg_we,
	input  logic [rtppcmu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rtppcmu_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam logic [9:0] MAX_LEN = 10'(MAX_FRAME_SAMPLES);
	localparam int unsigned PKT_SLOTS = rtppcmu_pkg::PACKET_SLOTS;

	logic [31:0] source_id_q;
	logic [6:0]  payload_kind_q;
	logic [7:0]  frame_length_q;
	logic [15:0] seq_q;
	logic [31:0] ts_q;
	logic [7:0]  pos_q;

	logic        valid_s1;
	logic [15:0] sample_s1;
	logic        marker_s1;
	logic [15:0] seq_s1;
	logic [31:0] ts_s1;
	logic        hdr_s1;
	logic        last_s1;
	logic [rtppcmu_pkg::BYTE_IDX_W-1:0] idx_s1;

	logic       in_acc;
	logic       out_load;
	logic       s1_done;
	logic [7:0] eff_len;
	logic       frame_last;

	logic        mu_sign;
	logic [16:0] mu_mag;
	logic [14:0] mu_biased;
	logic [2:0]  mu_expo;
	logic [3:0]  mu_mant;
	logic [7:0]  mu_byte;
	logic [7:0]  slot_bytes [PKT_SLOTS];

	// effective frame length: zero acts as one, saturate at the maximum
	always_comb begin
		if (frame_length_q == 8'd0) begin
			eff_len = 8'd1;
		end else if ({2'b00, frame_length_q} > MAX_LEN) begin
			eff_len = MAX_LEN[7:0];
		end else begin
			eff_len = frame_length_q;
		end
	end

	assign frame_last = ({1'b0, pos_q} + 9'd1) >= {1'b0, eff_len};
	assign out_load = valid_s1 && (!m_tvalid || m_tready);
	assign s1_done = out_load && (idx_s1 == rtppcmu_pkg::BYTE_IDX_PAYLOAD);
	assign s_tready = !valid_s1 || s1_done;
	assign in_acc = s_tvalid && s_tready;

	// config registers and running counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_id_q <= '0;
			payload_kind_q <= '0;
			frame_length_q <= rtppcmu_pkg::FRAME_LENGTH_RESET;
			seq_q <= '0;
			ts_q <= '0;
			pos_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rtppcmu_pkg::CFG_SOURCE_ID: source_id_q <= cfg_data;
				rtppcmu_pkg::CFG_START_SEQUENCE: seq_q <= cfg_data[15:0];
				rtppcmu_pkg::CFG_START_TIMESTAMP: ts_q <= cfg_data;
				rtppcmu_pkg::CFG_PAYLOAD_KIND: payload_kind_q <= cfg_data[6:0];
				rtppcmu_pkg::CFG_FRAME_LENGTH: frame_length_q <= cfg_data[7:0];
				default: ;
			endcase
		end else if (in_acc) begin
			if (frame_last) begin
				pos_q <= '0;
				seq_q <= seq_q + 16'd1;
				ts_q <= ts_q + {24'd0, eff_len};
			end else begin
				pos_q <= pos_q + 8'd1;
			end
		end
	end

	// sequencing stage: holds one sample and walks its output bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1 <= '0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
			idx_s1 <= (pos_q == 8'd0) ? rtppcmu_pkg::BYTE_IDX_FIRST
				: rtppcmu_pkg::BYTE_IDX_PAYLOAD;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end else if (out_load) begin
			idx_s1 <= idx_s1 + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1 <= s_tdata;
			marker_s1 <= s_tuser;
			seq_s1 <= seq_q;
			ts_s1 <= ts_q;
			hdr_s1 <= (pos_q == 8'd0);
			last_s1 <= frame_last;
		end
	end

	// G.711 mu-law encode
	always_comb begin
		mu_sign = sample_s1[15];
		mu_mag = mu_sign ? (17'h10000 - {1'b0, sample_s1}) : {1'b0, sample_s1};
		if (mu_mag > rtppcmu_pkg::MULAW_CLIP) begin
			mu_mag = rtppcmu_pkg::MULAW_CLIP;
		end
		mu_biased = mu_mag[14:0] + rtppcmu_pkg::MULAW_BIAS;
		priority casez (mu_biased[14:7])
			8'b1???????: mu_expo = 3'd7;
			8'b01??????: mu_expo = 3'd6;
			8'b001?????: mu_expo = 3'd5;
			8'b0001????: mu_expo = 3'd4;
			8'b00001???: mu_expo = 3'd3;
			8'b000001??: mu_expo = 3'd2;
			8'b0000001?: mu_expo = 3'd1;
			default:     mu_expo = 3'd0;
		endcase
		mu_mant = 4'((mu_biased >> ({1'b0, mu_expo} + 4'd3)) & 15'h000F);
		mu_byte = ~{mu_sign, mu_expo, mu_mant};
	end

	always_comb begin
		slot_bytes[0] = rtppcmu_pkg::RTP_VERSION_BYTE;
		slot_bytes[1] = {marker_s1, payload_kind_q};
		slot_bytes[2] = seq_s1[15:8];
		slot_bytes[3] = seq_s1[7:0];
		slot_bytes[4] = ts_s1[31:24];
		slot_bytes[5] = ts_s1[23:16];
		slot_bytes[6] = ts_s1[15:8];
		slot_bytes[7] = ts_s1[7:0];
		slot_bytes[8] = source_id_q[31:24];
		slot_bytes[9] = source_id_q[23:16];
		slot_bytes[10] = source_id_q[15:8];
		slot_bytes[11] = source_id_q[7:0];
		slot_bytes[12] = mu_byte;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= slot_bytes[idx_s1];
			m_tlast <= (idx_s1 == rtppcmu_pkg::BYTE_IDX_PAYLOAD) && last_s1;
		end
	end

	`RPP_ASSERT_NOW(a_idx_range, valid_s1, idx_s1 <= rtppcmu_pkg::BYTE_IDX_PAYLOAD)
	`RPP_ASSERT_NOW(a_nohdr_payload, valid_s1 && !hdr_s1, idx_s1 == rtppcmu_pkg::BYTE_IDX_PAYLOAD)
	`RPP_ASSERT_NEXT(a_frame_start, in_acc && (pos_q == 8'd0), hdr_s1 && (idx_s1 == rtppcmu_pkg::BYTE_IDX_FIRST))

endmodule

[sim/testbench.sv]
// Self-checking bench for the RTP mu-law packetizer: directed table, then random phases.
module testbench;

	typedef logic [rtppcmu_pkg::CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [rtppcmu_pkg::CFG_DATA_W-1:0] cfg_data_t;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_WORDS = 450;
	localparam int LEN_CAP = 255;
	localparam int MU_CLIP = 32635;
	localparam int MU_BIAS = 'h84;
	localparam int HOLD_CYCLES = 400;
	localparam cfg_idx_t CFG_SPARE_LO = 3'd5;
	localparam cfg_idx_t CFG_SPARE_HI = 3'd7;
	localparam cfg_idx_t R_SRC = rtppcmu_pkg::CFG_SOURCE_ID;
	localparam cfg_idx_t R_SEQ = rtppcmu_pkg::CFG_START_SEQUENCE;
	localparam cfg_idx_t R_TS = rtppcmu_pkg::CFG_START_TIMESTAMP;
	localparam cfg_idx_t R_PT = rtppcmu_pkg::CFG_PAYLOAD_KIND;
	localparam cfg_idx_t R_LEN = rtppcmu_pkg::CFG_FRAME_LENGTH;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser;
	logic [15:0] s_tdata;
	logic m_tvalid, m_tready, m_tlast;
	logic [7:0] m_tdata;
	logic cfg_we;
	cfg_idx_t cfg_index;
	cfg_data_t cfg_data;

	typedef struct packed {
		logic [7:0] data;
		logic last;
	} pkt_byte_t;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		cfg_idx_t index;
		cfg_data_t value;
		logic [15:0] sample;
		logic marker;
		logic typed;
		logic [7:0] code;
	} stim_row_t;

	pkt_byte_t expected_bytes[$];

	// packetizer state as predicted
	logic [31:0] ssrc_reg, ts_start, ts_now;
	logic [15:0] seq_start, seq_now;
	logic [6:0] pt_reg;
	logic [7:0] flen_reg, pos_now;

	int errors = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit quiet = 0;

	stim_row_t plan [37] = '{
		'{ROW_WORD, '0, '0, 16'h0000, 1'b1, 1'b1, 8'hFF},
		'{ROW_WORD, '0, '0, 16'h7FFF, 1'b0, 1'b1, 8'h80},
		'{ROW_WORD, '0, '0, 16'h8000, 1'b0, 1'b1, 8'h00},
		'{ROW_WORD, '0, '0, 16'h8001, 1'b1, 1'b1, 8'h00},
		'{ROW_WORD, '0, '0, 16'hFFFF, 1'b0, 1'b1, 8'h7F},
		'{ROW_WORD, '0, '0, 16'h0001, 1'b0, 1'b1, 8'hFF},
		// zero length mid-frame: next word closes the packet
		'{ROW_REG, R_LEN, 32'h0000_0000, '0, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'h1234, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'hEDCB, 1'b1, 1'b0, '0},
		'{ROW_REG, R_SRC, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
		'{ROW_REG, R_PT, 32'h0000_007F, '0, 1'b0, 1'b0, '0},
		'{ROW_REG, R_SEQ, 32'h0000_FFFF, '0, 1'b0, 1'b0, '0},
		'{ROW_REG, R_TS, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
		'{ROW_REG, R_LEN, 32'h0000_0003, '0, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'h4000, 1'b1, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'hC000, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'h00FF, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'hFF01, 1'b1, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'h0F0F, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'hF0F0, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'h5555, 1'b1, 1'b0, '0},
		// counters reloaded after the header went out
		'{ROW_REG, R_SEQ, 32'h0000_1234, '0, 1'b0, 1'b0, '0},
		'{ROW_REG, R_TS, 32'h89AB_CDEF, '0, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'hAAAA, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'h0080, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'h7F7F, 1'b1, 1'b0, '0},
		'{ROW_REG, CFG_SPARE_LO, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
		'{ROW_REG, R_PT, 32'hFFFF_FF80, '0, 1'b0, 1'b0, '0},
		'{ROW_REG, R_LEN, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'h2000, 1'b1, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'hDFFF, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'h0000, 1'b0, 1'b0, '0},
		// shortened below the current position
		'{ROW_REG, R_LEN, 32'h0000_0002, '0, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'h3FFF, 1'b0, 1'b0, '0},
		'{ROW_REG, R_SRC, 32'h0000_0000, '0, 1'b0, 1'b0, '0},
		'{ROW_REG, R_LEN, 32'h0000_0001, '0, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'h8000, 1'b0, 1'b0, '0}
	};

	rtp_pcmu_packetizer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic logic [7:0] mulaw_code(logic [15:0] smp);
		logic [16:0] mag;
		logic [7:0] c;
		int ex;
		int b;
		mag = smp[15] ? 17'h10000 - {1'b0, smp} : {1'b0, smp};
		if (mag > MU_CLIP)
			mag = 17'(MU_CLIP);
		mag = mag + 17'(MU_BIAS);
		ex = 0;
		for (b = 7; b <= 14; b++)
			if (mag[b])
				ex = b - 7;
		c = {smp[15], 3'(ex), mag[ex+3 +: 4]};
		return ~c;
	endfunction

	function automatic void push_byte(logic [7:0] d, logic l);
		expected_bytes.push_back(pkt_byte_t'{d, l});
	endfunction

	function automatic void predict_packet(logic [15:0] smp, logic mk);
		int len;
		int k;
		logic fin;
		len = (flen_reg == 0) ? 1 : int'(flen_reg);
		if (len > LEN_CAP)
			len = LEN_CAP;
		if (pos_now == 0) begin
			push_byte(rtppcmu_pkg::RTP_VERSION_BYTE, 1'b0);
			push_byte({mk, pt_reg}, 1'b0);
			push_byte(seq_now[15:8], 1'b0);
			push_byte(seq_now[7:0], 1'b0);
			for (k = 3; k >= 0; k--)
				push_byte(ts_now[8*k +: 8], 1'b0);
			for (k = 3; k >= 0; k--)
				push_byte(ssrc_reg[8*k +: 8], 1'b0);
		end
		fin = (int'(pos_now) + 1) >= len;
		push_byte(mulaw_code(smp), fin);
		if (fin) begin
			pos_now = '0;
			seq_now = seq_now + 16'd1;
			ts_now = ts_now + 32'(len);
		end else begin
			pos_now = pos_now + 8'd1;
		end
	endfunction

	function automatic void apply_reg(cfg_idx_t idx, cfg_data_t val);
		case (idx)
			R_SRC: ssrc_reg = val;
			R_SEQ: begin
				seq_start = val[15:0];
				seq_now = seq_start;
			end
			R_TS: begin
				ts_start = val;
				ts_now = ts_start;
			end
			R_PT: pt_reg = val[6:0];
			R_LEN: flen_reg = val[7:0];
			default: ;
		endcase
	endfunction

	function automatic logic [15:0] pick_sample();
		logic [15:0] v;
		int sh;
		if ($urandom_range(99) < 40)
			return 16'($urandom);
		sh = $urandom_range(15);
		v = 16'($urandom) & 16'((1 << sh) - 1);
		return $urandom_range(1) ? 16'(-v) : v;
	endfunction

	// all tasks below start and end at a falling edge
	task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, val);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic send_word(logic [15:0] smp, logic mk, logic typed, logic [7:0] code);
		while (!quiet && $urandom_range(99) < 14) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tuser <= mk;
		do
			@(posedge clk);
		while (!s_tready);
		predict_packet(smp, mk);
		if (typed)
			expected_bytes[expected_bytes.size()-1].data = code;
		@(negedge clk);
	endtask

	task automatic shuffle_regs();
		int r;
		logic [7:0] flen;
		if ($urandom_range(1))
			write_reg(R_SRC, $urandom);
		if ($urandom_range(1))
			write_reg(R_SEQ,
				$urandom_range(1) ? 32'($urandom) : 32'(16'hFFFF - $urandom_range(3)));
		if ($urandom_range(1))
			write_reg(R_TS,
				$urandom_range(1) ? 32'($urandom) : 32'hFFFF_FFFF - $urandom_range(600));
		if ($urandom_range(1))
			write_reg(R_PT, $urandom);
		r = $urandom_range(99);
		if (r < 8)
			flen = 8'd0;
		else if (r < 16)
			flen = 8'd255;
		else if (r < 24)
			flen = 8'($urandom_range(254, 13));
		else
			flen = 8'($urandom_range(12, 1));
		if ($urandom_range(3) != 0)
			write_reg(R_LEN, {$urandom_range(1) ? 24'($urandom) : 24'h0, flen});
		if ($urandom_range(9) == 0)
			write_reg(cfg_idx_t'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)), $urandom);
	endtask

	always @(posedge clk) begin : byte_check
		pkt_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected word: packet_byte %h end_of_packet %b", m_tdata, m_tlast);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				if (m_tdata !== want.data) begin
					$error("packet_byte: expected %h, got %h", want.data, m_tdata);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("end_of_packet: expected %b, got %b", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= quiet || ($urandom_range(99) >= 14);
			end
		end
	end

	initial begin
		int sent;
		int phase;
		int n;
		int i;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = R_SRC;
		cfg_data = '0;
		ssrc_reg = '0;
		seq_start = '0;
		seq_now = '0;
		ts_start = '0;
		ts_now = '0;
		pt_reg = '0;
		flen_reg = rtppcmu_pkg::FRAME_LENGTH_RESET;
		pos_now = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_REG) begin
				drain();
				write_reg(plan[k].index, plan[k].value);
			end else begin
				send_word(plan[k].sample, plan[k].marker, plan[k].typed, plan[k].code);
			end
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			drain();
			shuffle_regs();
			quiet = (phase == 4);
			if (phase == 2)
				hold_left = HOLD_CYCLES;
			n = quiet ? 60 : $urandom_range(40, 10);
			for (i = 0; i < n; i++)
				send_word(pick_sample(), 1'($urandom_range(1)), 1'b0, '0);
			sent += n;
			phase++;
		end
		quiet = 0;
		drain();
		repeat (20) @(negedge clk);

		if (expected_bytes.size() != 0) begin
			$error("%0d expected words never arrived", expected_bytes.size());
			errors++;
		end
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

[rtp_pcmu_packetizer_top.f]
+incdir+rtl
rtl/rtppcmu_pkg.sv
rtl/rtp_pcmu_packetizer_top.sv
sim/testbench.sv
